>>> hdl/rpi_pkg.sv
// Shared widths, register codes, stage payload types and saturation helper
// for the ray / plane intersection pipeline. No dependencies.
`timescale 1ns / 1ps

package rpi_pkg;

    localparam int NW  = 18;           // normal component width
    localparam int CW  = 32;           // coordinate width
    localparam int PW  = NW + CW;      // normal x coordinate product
    localparam int SW  = PW + 2;       // sum of three products
    localparam int AW  = SW - 1;       // magnitude of a dot product
    localparam int RW  = AW + 1;       // divider partial remainder
    localparam int QW  = 33;           // quotient bits, Q16.16 plus overflow
    localparam int FW  = PW + 1 - 16;  // foot point coordinate
    localparam int TW  = FW + 1;       // start minus foot
    localparam int EW  = TW + NW;      // (start minus foot) x normal
    localparam int DW  = EW + 2;       // sum of three such products
    localparam int XW  = 64;           // direction x t product

    localparam logic [2:0] REG_NORMAL_X = 3'd0;
    localparam logic [2:0] REG_NORMAL_Y = 3'd1;
    localparam logic [2:0] REG_NORMAL_Z = 3'd2;
    localparam logic [2:0] REG_OFFSET   = 3'd3;
    localparam logic [2:0] REG_PAR_EPS  = 3'd4;
    localparam logic [2:0] REG_NEAR_EPS = 3'd5;

    localparam logic [CW-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [CW-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [2:0][CW-1:0] s;
        logic [2:0][CW-1:0] v;
        logic [2:0][FW-1:0] foot;
        logic               par;
        logic               near;
        logic               inplane;
        logic               neg;
    } t_side;

    typedef struct packed {
        logic               is_hit;
        logic [CW-1:0]      t;
        logic [2:0][CW-1:0] hit;
    } t_res;

    function automatic logic [CW-1:0] sat32(input logic signed [XW-1:0] x);
        logic [CW-1:0] r;
        if (x > 64'sd2147483647) begin
            r = SAT_MAX;
        end else if (x < -64'sd2147483648) begin
            r = SAT_MIN;
        end else begin
            r = x[CW-1:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/ray_plane_intersect_top.sv
// Ray / plane intersection top level: APB register file, dot-product front
// end, one-bit-per-stage pipelined divider and hit-point back end. Uses rpi_pkg.
`timescale 1ns / 1ps

// Throughput: one word per cycle while o_stall is low; the 33-stage
// restoring divider (one quotient bit per stage) sets the depth, not the rate.
// A two-entry output (register plus skid) keeps accepting until the skid fills.
// Reset (synchronous, active low) clears all valids and loads the plane
// registers with normal (0,0,1), offset 0 and both epsilons 1.
module ray_plane_intersect_top
    import rpi_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    // ray words in
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [31:0]   i_start_x,
    input  logic [31:0]   i_start_y,
    input  logic [31:0]   i_start_z,
    input  logic [31:0]   i_dir_x,
    input  logic [31:0]   i_dir_y,
    input  logic [31:0]   i_dir_z,
    // results out
    output logic          o_valid,
    input  logic          i_stall,
    output logic          o_is_hit,
    output logic [31:0]   o_param_t,
    output logic [31:0]   o_hit_x,
    output logic [31:0]   o_hit_y,
    output logic [31:0]   o_hit_z
);

    // ------------------------------------------------------------------
    // Plane registers
    // ------------------------------------------------------------------
    logic signed [NW-1:0] r_nrm [3];
    logic signed [CW-1:0] r_off;
    logic [15:0]          r_peps;
    logic [15:0]          r_neps;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nrm[0] <= '0;
            r_nrm[1] <= '0;
            r_nrm[2] <= NW'(65536);
            r_off    <= '0;
            r_peps   <= 16'd1;
            r_neps   <= 16'd1;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                REG_NORMAL_X: r_nrm[0] <= pwdata[NW-1:0];
                REG_NORMAL_Y: r_nrm[1] <= pwdata[NW-1:0];
                REG_NORMAL_Z: r_nrm[2] <= pwdata[NW-1:0];
                REG_OFFSET:   r_off    <= pwdata;
                REG_PAR_EPS:  r_peps   <= pwdata[15:0];
                REG_NEAR_EPS: r_neps   <= pwdata[15:0];
                default: ;    // drop writes beyond the register list
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_NORMAL_X: prdata = 32'(r_nrm[0]);
            REG_NORMAL_Y: prdata = 32'(r_nrm[1]);
            REG_NORMAL_Z: prdata = 32'(r_nrm[2]);
            REG_OFFSET:   prdata = r_off;
            REG_PAR_EPS:  prdata = {16'd0, r_peps};
            REG_NEAR_EPS: prdata = {16'd0, r_neps};
            default:      prdata = '0;
        endcase
    end

    // Parallel epsilon in Q20.32, never negative.
    logic signed [SW-1:0] w_e;
    assign w_e = SW'({r_peps, 16'd0});

    // The whole pipe advances together; only a full skid entry holds it.
    logic en;
    logic r_sv;
    assign en      = !r_sv;
    assign o_stall = r_sv;

    logic signed [CW-1:0] w_s [3];
    logic signed [CW-1:0] w_v [3];
    assign w_s[0] = i_start_x;
    assign w_s[1] = i_start_y;
    assign w_s[2] = i_start_z;
    assign w_v[0] = i_dir_x;
    assign w_v[1] = i_dir_y;
    assign w_v[2] = i_dir_z;

    // ------------------------------------------------------------------
    // Stage A: the nine normal products
    // ------------------------------------------------------------------
    logic                 r_a_vld;
    logic signed [PW-1:0] r_a_ns [3];
    logic signed [PW-1:0] r_a_nv [3];
    logic signed [PW-1:0] r_a_nd [3];
    logic signed [CW-1:0] r_a_s  [3];
    logic signed [CW-1:0] r_a_v  [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_a_ns[i] <= w_s[i] * r_nrm[i];
                r_a_nv[i] <= w_v[i] * r_nrm[i];
                r_a_nd[i] <= r_off * r_nrm[i];
                r_a_s[i]  <= w_s[i];
                r_a_v[i]  <= w_v[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage B: dot products, numerator, foot point, start minus foot
    // ------------------------------------------------------------------
    logic                 r_b_vld;
    logic signed [SW-1:0] r_b_dnv;
    logic signed [SW-1:0] r_b_num;
    logic signed [FW-1:0] r_b_foot [3];
    logic signed [TW-1:0] r_b_tmp  [3];
    logic signed [CW-1:0] r_b_s    [3];
    logic signed [CW-1:0] r_b_v    [3];

    logic signed [PW:0]   w_nf   [3];
    logic signed [FW-1:0] w_foot [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // round half up: floor((x + 0.5) in Q16.16)
            w_nf[i]   = -(PW+1)'(r_a_nd[i]) + (PW+1)'(32768);
            w_foot[i] = w_nf[i][PW:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_dnv <= SW'(r_a_nv[0]) + SW'(r_a_nv[1]) + SW'(r_a_nv[2]);
            r_b_num <= (SW'(r_off) <<< 16) + SW'(r_a_ns[0]) + SW'(r_a_ns[1])
                       + SW'(r_a_ns[2]);
            for (int i = 0; i < 3; i++) begin
                r_b_foot[i] <= w_foot[i];
                r_b_tmp[i]  <= TW'(r_a_s[i]) - TW'(w_foot[i]);
                r_b_s[i]    <= r_a_s[i];
                r_b_v[i]    <= r_a_v[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage C: parallel test, magnitudes, squares and second dot terms
    // ------------------------------------------------------------------
    logic                 r_c_vld;
    logic                 r_c_par;
    logic                 r_c_neg;
    logic [AW-1:0]        r_c_an;
    logic [AW-1:0]        r_c_ad;
    logic                 r_c_nall;
    logic [31:0]          r_c_sq [3];
    logic signed [EW-1:0] r_c_dp [3];
    logic [31:0]          r_c_neps2;
    logic signed [FW-1:0] r_c_foot [3];
    logic signed [CW-1:0] r_c_s    [3];
    logic signed [CW-1:0] r_c_v    [3];

    logic [SW-1:0] w_an;
    logic [SW-1:0] w_ad;
    logic [TW-1:0] w_at [3];
    logic          w_nall;

    always_comb begin
        w_an   = r_b_num[SW-1] ? SW'(-r_b_num) : r_b_num;
        w_ad   = r_b_dnv[SW-1] ? SW'(-r_b_dnv) : r_b_dnv;
        w_nall = 1'b1;
        for (int i = 0; i < 3; i++) begin
            w_at[i] = r_b_tmp[i][TW-1] ? TW'(-r_b_tmp[i]) : r_b_tmp[i];
            if (w_at[i] >= TW'(r_neps)) begin
                w_nall = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_par   <= (r_b_dnv == '0) || ((r_b_dnv > -w_e) && (r_b_dnv < w_e));
            r_c_neg   <= ((r_b_num > 0) && (r_b_dnv > 0))
                         || ((r_b_num < 0) && (r_b_dnv < 0));
            r_c_an    <= w_an[AW-1:0];
            r_c_ad    <= w_ad[AW-1:0];
            r_c_nall  <= w_nall;
            r_c_neps2 <= r_neps * r_neps;
            for (int i = 0; i < 3; i++) begin
                // only read when every |tmp| is below near_eps, so 16 bits do
                r_c_sq[i]   <= w_at[i][15:0] * w_at[i][15:0];
                r_c_dp[i]   <= r_b_tmp[i] * r_nrm[i];
                r_c_foot[i] <= r_b_foot[i];
                r_c_s[i]    <= r_b_s[i];
                r_c_v[i]    <= r_b_v[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage D (divider entry): near and in-plane flags, divider set-up
    // ------------------------------------------------------------------
    logic [33:0]          w_sqs;
    logic signed [DW-1:0] w_dot2;
    t_side                w_side0;

    always_comb begin
        w_sqs  = 34'(r_c_sq[0]) + 34'(r_c_sq[1]) + 34'(r_c_sq[2]);
        w_dot2 = DW'(r_c_dp[0]) + DW'(r_c_dp[1]) + DW'(r_c_dp[2]);
        for (int i = 0; i < 3; i++) begin
            w_side0.s[i]    = r_c_s[i];
            w_side0.v[i]    = r_c_v[i];
            w_side0.foot[i] = r_c_foot[i];
        end
        w_side0.par     = r_c_par;
        w_side0.near    = r_c_nall && (w_sqs < 34'(r_c_neps2));
        w_side0.inplane = (w_dot2 > -DW'(w_e)) && (w_dot2 < DW'(w_e));
        w_side0.neg     = r_c_neg;
    end

    // Restoring division of an * 2^16 by ad, one quotient bit per stage.
    // The top of the numerator seeds the remainder; if it already reaches
    // the divisor the quotient needs more than 33 bits and saturates.
    logic          r_dv_vld [QW+1];
    logic [RW-1:0] r_rem    [QW+1];
    logic [QW-1:0] r_nb     [QW+1];
    logic [QW-1:0] r_quo    [QW+1];
    logic [AW-1:0] r_ad     [QW+1];
    logic          r_ovf    [QW+1];
    t_side         r_side   [QW+1];

    logic [RW-1:0] w_trial [QW];
    logic [RW-1:0] w_rem   [QW];
    logic          w_qb    [QW];

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            w_trial[k] = {r_rem[k][RW-2:0], r_nb[k][QW-1]};
            w_qb[k]    = w_trial[k] >= RW'(r_ad[k]);
            w_rem[k]   = w_qb[k] ? (w_trial[k] - RW'(r_ad[k])) : w_trial[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0]  <= RW'(r_c_an[AW-1:17]);
            r_nb[0]   <= {r_c_an[16:0], 16'd0};
            r_quo[0]  <= '0;
            r_ad[0]   <= r_c_ad;
            r_ovf[0]  <= AW'(r_c_an[AW-1:17]) >= r_c_ad;
            r_side[0] <= w_side0;
            for (int k = 0; k < QW; k++) begin
                r_rem[k+1]  <= w_rem[k];
                r_nb[k+1]   <= {r_nb[k][QW-2:0], 1'b0};
                r_quo[k+1]  <= {r_quo[k][QW-2:0], w_qb[k]};
                r_ad[k+1]   <= r_ad[k];
                r_ovf[k+1]  <= r_ovf[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage E: sign and saturate t
    // ------------------------------------------------------------------
    logic          r_e_vld;
    logic [CW-1:0] r_e_t;
    t_side         r_e_side;
    logic [QW-1:0] w_m;
    logic [CW-1:0] w_t;

    always_comb begin
        w_m = r_quo[QW];
        if (r_side[QW].par) begin
            w_t = '0;
        end else if (r_ovf[QW]) begin
            w_t = r_side[QW].neg ? SAT_MIN : SAT_MAX;
        end else if (r_side[QW].neg) begin
            w_t = (w_m > QW'(33'h0_8000_0000)) ? SAT_MIN : (~w_m[CW-1:0] + 32'd1);
        end else begin
            w_t = (w_m > QW'(33'h0_7FFF_FFFF)) ? SAT_MAX : w_m[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_t    <= w_t;
            r_e_side <= r_side[QW];
        end
    end

    // ------------------------------------------------------------------
    // Stage F: direction x t
    // ------------------------------------------------------------------
    logic                 r_f_vld;
    logic signed [XW-1:0] r_f_p [3];
    logic [CW-1:0]        r_f_t;
    t_side                r_f_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_f_p[i] <= $signed(r_e_side.v[i]) * $signed(r_e_t);
            end
            r_f_t    <= r_e_t;
            r_f_side <= r_e_side;
        end
    end

    // Round the products, add the start, saturate, pick the case.
    logic signed [XW-1:0] w_x [3];
    t_res                 w_res;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_x[i] = r_f_p[i] + 64'sd32768;
        end
        w_res.t      = r_f_t;
        w_res.is_hit = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (!r_f_side.par) begin
                w_res.hit[i] = sat32(XW'($signed(r_f_side.s[i]))
                                     + XW'($signed(w_x[i][XW-1:16])));
            end else if (r_f_side.near) begin
                w_res.hit[i] = sat32(XW'($signed(r_f_side.foot[i])));
            end else if (r_f_side.inplane) begin
                w_res.hit[i] = r_f_side.s[i];
            end else begin
                w_res.hit[i] = '0;
            end
        end
        if (r_f_side.par && !r_f_side.near && !r_f_side.inplane) begin
            w_res.is_hit = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid entry
    // ------------------------------------------------------------------
    logic r_ov;
    t_res r_o;
    t_res r_k;
    logic take;
    assign take = r_ov && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            for (int k = 0; k <= QW; k++) begin
                r_dv_vld[k] <= 1'b0;
            end
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_ov    <= 1'b0;
            r_sv    <= 1'b0;
        end else begin
            if (en) begin
                r_a_vld     <= i_valid;
                r_b_vld     <= r_a_vld;
                r_c_vld     <= r_b_vld;
                r_dv_vld[0] <= r_c_vld;
                for (int k = 0; k < QW; k++) begin
                    r_dv_vld[k+1] <= r_dv_vld[k];
                end
                r_e_vld <= r_dv_vld[QW];
                r_f_vld <= r_e_vld;
            end
            if (r_sv) begin
                // pipe held: drain the skid entry into the output register
                if (take) begin
                    r_sv <= 1'b0;
                end
            end else if (!r_ov || take) begin
                r_ov <= r_f_vld;
            end else if (r_f_vld) begin
                r_sv <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (take) begin
                r_o <= r_k;
            end
        end else if (!r_ov || take) begin
            r_o <= w_res;
        end else begin
            r_k <= w_res;
        end
    end

    assign o_valid   = r_ov;
    assign o_is_hit  = r_o.is_hit;
    assign o_param_t = r_o.t;
    assign o_hit_x   = r_o.hit[0];
    assign o_hit_y   = r_o.hit[1];
    assign o_hit_z   = r_o.hit[2];

endmodule
